/* rtl/pkvt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkvt_pkg
// Shared types and constants for the properties key/value tokenizer.
// ----------------------------------------------------------------------------
package pkvt_pkg;

  localparam int RUN_MAX = 3;   // most results one input byte can cause
  localparam int QDEPTH  = 4;   // entries in the front-to-back queue
  localparam int QPTR_W  = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    KIND_KEY = 2'd0,
    KIND_VAL = 2'd1,
    KIND_END = 2'd2
  } kind_t;

  // All results of one input byte, oldest in slot 0.
  typedef struct packed {
    logic [1:0]                cnt;
    kind_t [RUN_MAX-1:0]       kind;
    logic [RUN_MAX-1:0][15:0]  code;
  } run_t;

endpackage
`default_nettype wire

/* rtl/pkvt_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkvt_front
// Parser state machine: takes one byte per cycle while accept is high and
// builds the run of tokens it causes.
// ----------------------------------------------------------------------------
module pkvt_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   in_byte,
  input  wire logic         stream_end,
  output logic              push,
  output pkvt_pkg::run_t    run
);
  import pkvt_pkg::*;

  typedef enum logic [2:0] {
    MODE_LINE = 3'd0,
    MODE_CMNT = 3'd1,
    MODE_KEY  = 3'd2,
    MODE_SEPA = 3'd3,
    MODE_SEPB = 3'd4,
    MODE_VAL  = 3'd5,
    MODE_CONT = 3'd6,
    MODE_HEX  = 3'd7
  } mode_t;

  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_COL  = 8'h3A;
  localparam logic [7:0] CH_EQ   = 8'h3D;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_U    = 8'h75;

  mode_t       mode, mode_next;
  logic        esc, esc_next;
  logic [15:0] hacc, hacc_next;
  logic [2:0]  hcnt, hcnt_next;
  logic        inv, inv_next;

  function automatic run_t add_tok(run_t r, kind_t k, logic [15:0] c);
    run_t o;
    o = r;
    if (r.cnt != 2'd3) begin
      o.kind[r.cnt] = k;
      o.code[r.cnt] = c;
      o.cnt         = r.cnt + 2'd1;
    end
    return o;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= 8'h30 && b <= 8'h39)      r = {1'b1, b[3:0]};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, b[3:0] + 4'd9};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  always_comb begin
    logic       done;
    logic       blank;
    logic       sep;
    logic [4:0] hd;
    kind_t      kcur;
    mode_t      m;

    m     = mode;
    esc_next  = esc;
    hacc_next = hacc;
    hcnt_next = hcnt;
    inv_next  = inv;
    run       = '0;
    done      = 1'b0;
    blank = (in_byte == CH_SP) || (in_byte == CH_TAB) || (in_byte == CH_FF);
    sep   = (in_byte == CH_COL) || (in_byte == CH_EQ);
    hd    = hex_digit(in_byte);

    // At most two passes are live: a mode change hands the byte on once.
    for (int p = 0; p < 4; p++) begin
      if (!done) begin
        kcur = inv_next ? KIND_VAL : KIND_KEY;
        unique case (m)
          MODE_CMNT: begin
            if (in_byte == CH_LF) m = MODE_LINE;
            done = 1'b1;
          end
          MODE_KEY, MODE_VAL: begin
            done = 1'b1;
            if (esc_next) begin
              esc_next = 1'b0;
              if (in_byte == CH_N)       run = add_tok(run, kcur, 16'd10);
              else if (in_byte == CH_T)  run = add_tok(run, kcur, 16'd9);
              else if (in_byte == CH_R)  run = add_tok(run, kcur, 16'd13);
              else if (in_byte == CH_U) begin
                m = MODE_HEX;
                hacc_next = '0;
                hcnt_next = '0;
              end
              else if (in_byte == CH_LF) m = MODE_CONT;
              else run = add_tok(run, kcur, {8'h00, in_byte});
            end else if (in_byte == CH_BSL) begin
              esc_next = 1'b1;
            end else if (in_byte == CH_LF) begin
              run = add_tok(run, KIND_END, 16'd0);
              m = MODE_LINE;
              esc_next = 1'b0;
              inv_next = 1'b0;
            end else if (!inv_next && blank) begin
              m = MODE_SEPA;
            end else if (!inv_next && sep) begin
              m = MODE_SEPB;
            end else begin
              run = add_tok(run, kcur, {8'h00, in_byte});
            end
          end
          MODE_SEPA, MODE_SEPB: begin
            if (blank) begin
              done = 1'b1;
            end else if (in_byte == CH_LF) begin
              run = add_tok(run, KIND_END, 16'd0);
              m = MODE_LINE;
              esc_next = 1'b0;
              inv_next = 1'b0;
              done = 1'b1;
            end else if (m == MODE_SEPA && sep) begin
              m = MODE_SEPB;
              done = 1'b1;
            end else begin
              m = MODE_VAL;
              inv_next = 1'b1;
            end
          end
          MODE_CONT: begin
            if (blank) done = 1'b1;
            else m = inv_next ? MODE_VAL : MODE_KEY;
          end
          MODE_HEX: begin
            if (hd[4]) begin
              done = 1'b1;
              hacc_next = {hacc_next[11:0], hd[3:0]};
              hcnt_next = hcnt_next + 3'd1;
              if (hcnt_next >= 3'd4) begin
                run = add_tok(run, kcur, hacc_next);
                hacc_next = '0;
                hcnt_next = '0;
                m = inv_next ? MODE_VAL : MODE_KEY;
              end
            end else begin
              // short escape: flush the code unit, then reparse the byte
              run = add_tok(run, kcur, hacc_next);
              hacc_next = '0;
              hcnt_next = '0;
              m = inv_next ? MODE_VAL : MODE_KEY;
            end
          end
          MODE_LINE: begin
            if (blank || in_byte == CH_LF) begin
              done = 1'b1;
            end else if (in_byte == CH_HASH || in_byte == CH_BANG) begin
              m = MODE_CMNT;
              done = 1'b1;
            end else begin
              m = MODE_KEY;
              inv_next = 1'b0;
              esc_next = 1'b0;
            end
          end
          default: done = 1'b1;
        endcase
      end
    end

    mode_next = m;
    if (stream_end) begin
      kcur = inv_next ? KIND_VAL : KIND_KEY;
      if (m == MODE_HEX) run = add_tok(run, kcur, hacc_next);
      if (m != MODE_LINE && m != MODE_CMNT) run = add_tok(run, KIND_END, 16'd0);
      mode_next = MODE_LINE;
      esc_next  = 1'b0;
      hacc_next = '0;
      hcnt_next = '0;
      inv_next  = 1'b0;
    end
  end

  assign push = accept && (run.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_LINE;
      esc  <= 1'b0;
      hacc <= '0;
      hcnt <= '0;
      inv  <= 1'b0;
    end else if (accept) begin
      mode <= mode_next;
      esc  <= esc_next;
      hacc <= hacc_next;
      hcnt <= hcnt_next;
      inv  <= inv_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/pkvt_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkvt_queue
// Short queue of token runs between the parser and the output stage.
// ----------------------------------------------------------------------------
module pkvt_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire pkvt_pkg::run_t push_run,
  input  wire logic           pop,
  output pkvt_pkg::run_t      head,
  output logic                empty,
  output logic                full
);
  import pkvt_pkg::*;

  run_t              store [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign head  = store[rptr];
  assign empty = (count == '0);
  assign full  = (count == (QPTR_W+1)'(QDEPTH));

  always_ff @(posedge clk) begin
    if (push) store[wptr] <= push_run;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/pkvt_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkvt_back
// Output stage: unpacks each queued run into single tokens, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pkvt_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire pkvt_pkg::run_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_stall,
  output logic [1:0]          token_kind,
  output logic [15:0]         char_code,
  output logic                run_last
);
  import pkvt_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !empty && (!out_valid || !out_stall);
  assign at_end = (idx == head.cnt - 2'd1);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= at_end ? 2'd0 : idx + 2'd1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      token_kind <= head.kind[idx];
      char_code  <= head.code[idx];
      run_last   <= at_end;
    end
  end

endmodule
`default_nettype wire

/* rtl/properties_key_value_tokenizer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// properties_key_value_tokenizer_core
// Byte-serial tokenizer for properties text: key, value and pair-end tokens.
// ----------------------------------------------------------------------------
// One input byte is taken per clock while the internal run queue (four runs
// deep) has room. The parser decodes the byte combinationally into a run of
// zero to three tokens; the output stage then hands out one token per clock
// while out_stall is low, so a byte yielding several tokens holds the output
// until each of them is taken. With the queue empty and the output free, the
// first token of a byte is written into the queue and then into the output
// registers before it reaches the outputs. Tokens leave in order, with
// run_last set on the final token of each byte.
module properties_key_value_tokenizer_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        stream_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       token_kind,
  output logic [15:0]      char_code,
  output logic             run_last
);
  import pkvt_pkg::*;

  logic accept;
  logic push;
  logic pop;
  logic empty;
  logic full;
  run_t run;
  run_t head;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  pkvt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .in_byte    (in_byte),
    .stream_end (stream_end),
    .push       (push),
    .run        (run)
  );

  pkvt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_run (run),
    .pop      (pop),
    .head     (head),
    .empty    (empty),
    .full     (full)
  );

  pkvt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_kind (token_kind),
    .char_code  (char_code),
    .run_last   (run_last)
  );

endmodule
`default_nettype wire

/* sim/tb_properties_key_value_tokenizer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb_properties_key_value_tokenizer_core
// Byte-stream check of the properties tokenizer. A directed table walks
// comments, separators, escapes, unicode escapes and end-of-text handling.
// Random lines of properties text follow. Every request runs through a
// behavioral tokenizer kept in the bench (typed table rows bring their own
// tokens), and each token that leaves is compared with the oldest due token.
// ----------------------------------------------------------------------------
module tb_properties_key_value_tokenizer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pkvt_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RANDOM_BYTES = 120;
  localparam int TAIL_CYCLES  = 32;
  localparam int IDLE_LIMIT   = 2000;

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_BSL   = 8'h5C;

  typedef enum logic [3:0] {
    PM_LINE, PM_CMNT, PM_KEY, PM_SEPA, PM_SEPB, PM_VAL, PM_CONT, PM_HEX
  } parse_mode_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] code;
    logic        last;
  } token_t;

  // One request of the directed table; typed rows carry their tokens.
  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic        typed;
    logic [1:0]  cnt;
    kind_t       k0;
    logic [15:0] c0;
    kind_t       k1;
    logic [15:0] c1;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        stream_end;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  token_kind;
  logic [15:0] char_code;
  logic        run_last;

  // tokenizer state of the bench
  parse_mode_t pmode;
  logic        esc_held;
  logic [15:0] hex_acc;
  logic [2:0]  hex_cnt;
  logic        in_value;
  token_t      run_buf [3];
  int          run_n;

  token_t      due_tokens[$];
  logic [7:0]  line_q[$];
  plan_row_t   dir_plan[$];
  int          mismatches = 0;

  properties_key_value_tokenizer_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .stream_end (stream_end),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_kind (token_kind),
    .char_code  (char_code),
    .run_last   (run_last)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // --------------------------------------------------------------------------
  // Behavioral tokenizer
  // --------------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] b);
    return b == CH_SP || b == CH_TAB || b == CH_FF;
  endfunction

  function automatic logic is_sep(input logic [7:0] b);
    return b == CH_COLON || b == CH_EQ;
  endfunction

  function automatic int hex_value(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 48;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 87;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 55;
    return -1;
  endfunction

  function automatic kind_t text_kind();
    return in_value ? KIND_VAL : KIND_KEY;
  endfunction

  function automatic parse_mode_t body_mode();
    return in_value ? PM_VAL : PM_KEY;
  endfunction

  task automatic tokenizer_clear();
    pmode    = PM_LINE;
    esc_held = 1'b0;
    hex_acc  = '0;
    hex_cnt  = '0;
    in_value = 1'b0;
  endtask

  task automatic put_token(input kind_t k, input logic [15:0] c);
    if (run_n < 3) begin
      run_buf[run_n] = {k, c, 1'b0};
      run_n++;
    end
  endtask

  task automatic close_pair();
    put_token(KIND_END, 16'h0000);
    pmode    = PM_LINE;
    esc_held = 1'b0;
    in_value = 1'b0;
  endtask

  task automatic body_char(input logic [7:0] b);
    kind_t k;
    k = text_kind();
    if (esc_held) begin
      esc_held = 1'b0;
      case (b)
        "n":     put_token(k, 16'd10);
        "t":     put_token(k, 16'd9);
        "r":     put_token(k, 16'd13);
        "u":     begin pmode = PM_HEX; hex_acc = '0; hex_cnt = '0; end
        CH_LF:   pmode = PM_CONT;
        default: put_token(k, {8'h00, b});
      endcase
    end else if (b == CH_BSL) begin
      esc_held = 1'b1;
    end else if (b == CH_LF) begin
      close_pair();
    end else if (!in_value && is_blank(b)) begin
      pmode = PM_SEPA;
    end else if (!in_value && is_sep(b)) begin
      pmode = PM_SEPB;
    end else begin
      put_token(k, {8'h00, b});
    end
  endtask

  task automatic scan_byte(input logic [7:0] b);
    logic done;
    int   d;
    int   pass;
    done = 1'b0;
    // a byte falls through at most one mode change before it is consumed
    for (pass = 0; pass < 4 && !done; pass++) begin
      case (pmode)
        PM_CMNT: begin
          if (b == CH_LF) pmode = PM_LINE;
          done = 1'b1;
        end
        PM_KEY, PM_VAL: begin
          body_char(b);
          done = 1'b1;
        end
        PM_SEPA, PM_SEPB: begin
          if (is_blank(b)) begin
            done = 1'b1;
          end else if (b == CH_LF) begin
            close_pair();
            done = 1'b1;
          end else if (pmode == PM_SEPA && is_sep(b)) begin
            pmode = PM_SEPB;
            done  = 1'b1;
          end else begin
            pmode    = PM_VAL;
            in_value = 1'b1;
          end
        end
        PM_CONT: begin
          if (is_blank(b)) done = 1'b1;
          else pmode = body_mode();
        end
        PM_HEX: begin
          d = hex_value(b);
          if (d >= 0) begin
            hex_acc = {hex_acc[11:0], 4'(d)};
            hex_cnt = hex_cnt + 3'd1;
            if (hex_cnt >= 3'd4) begin
              put_token(text_kind(), hex_acc);
              hex_acc = '0;
              hex_cnt = '0;
              pmode   = body_mode();
            end
            done = 1'b1;
          end else begin
            // short escape: flush the code unit, then reprocess the byte
            put_token(text_kind(), hex_acc);
            hex_acc = '0;
            hex_cnt = '0;
            pmode   = body_mode();
          end
        end
        default: begin
          pmode = PM_LINE;
          if (is_blank(b) || b == CH_LF) begin
            done = 1'b1;
          end else if (b == CH_HASH || b == CH_BANG) begin
            pmode = PM_CMNT;
            done  = 1'b1;
          end else begin
            pmode    = PM_KEY;
            in_value = 1'b0;
            esc_held = 1'b0;
          end
        end
      endcase
    end
  endtask

  task automatic predict_tokens(input logic [7:0] b, input logic fin);
    run_n = 0;
    scan_byte(b);
    if (fin) begin
      if (pmode == PM_HEX) put_token(text_kind(), hex_acc);
      if (pmode != PM_LINE && pmode != PM_CMNT) put_token(KIND_END, 16'h0000);
      tokenizer_clear();
    end
    if (run_n > 0) run_buf[run_n-1].last = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic plan_row_t plan_row(input logic [7:0] b, input logic fin,
                                         input logic typed, input logic [1:0] cnt = 2'd0,
                                         input kind_t k0 = KIND_KEY,
                                         input logic [15:0] c0 = 16'h0000,
                                         input kind_t k1 = KIND_KEY,
                                         input logic [15:0] c1 = 16'h0000);
    return {b, fin, typed, cnt, k0, c0, k1, c1};
  endfunction

  // mostly short pauses, now and then a long one
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 19);
    if (r < 10) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 2))
      0:       return CH_SP;
      1:       return CH_TAB;
      default: return CH_FF;
    endcase
  endfunction

  function automatic logic [7:0] text_char();
    case ($urandom_range(0, 9))
      0:       return 8'($urandom_range(128, 255));
      1:       return $urandom_range(0, 1) ? CH_CR : 8'h00;
      2:       return 8'($urandom_range(8'h21, 8'h7E));
      default: return 8'($urandom_range(8'h61, 8'h7A));
    endcase
  endfunction

  function automatic logic [7:0] hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(v - 10);
  endfunction

  task automatic add_escape();
    int n;
    line_q.push_back(CH_BSL);
    case ($urandom_range(0, 6))
      0: line_q.push_back("n");
      1: line_q.push_back("t");
      2: line_q.push_back("r");
      3: begin
        line_q.push_back("u");
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
        repeat (n) line_q.push_back(hex_char());
      end
      4: begin
        line_q.push_back(CH_LF);
        n = $urandom_range(0, 3);
        repeat (n) line_q.push_back(blank_char());
      end
      default: line_q.push_back(text_char());
    endcase
  endtask

  task automatic add_text(input int n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) add_escape();
      else line_q.push_back(text_char());
    end
  endtask

  task automatic compose_line();
    int n;
    n = $urandom_range(0, 2);
    repeat (n) line_q.push_back(blank_char());
    case ($urandom_range(0, 9))
      0: begin
        line_q.push_back($urandom_range(0, 1) ? CH_HASH : CH_BANG);
        n = $urandom_range(0, 6);
        repeat (n) line_q.push_back(text_char());
        line_q.push_back(CH_LF);
      end
      1: begin
        n = $urandom_range(1, 6);
        repeat (n) line_q.push_back(8'($urandom));
      end
      default: begin
        add_text($urandom_range(1, 4));
        case ($urandom_range(0, 4))
          0: line_q.push_back(CH_COLON);
          1: line_q.push_back(CH_EQ);
          2: line_q.push_back(blank_char());
          3: begin
            line_q.push_back(blank_char());
            line_q.push_back($urandom_range(0, 1) ? CH_COLON : CH_EQ);
            line_q.push_back(blank_char());
          end
          default: ;
        endcase
        add_text($urandom_range(0, 6));
        line_q.push_back(CH_LF);
      end
    endcase
  endtask

  // Entered and left at a falling edge.
  task automatic send_byte(input plan_row_t r, input int gap);
    in_byte    <= r.b;
    stream_end <= r.fin;
    in_valid   <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tokens(r.b, r.fin);
    if (r.typed) begin
      if (r.cnt > 0) due_tokens.push_back({r.k0, r.c0, r.cnt == 2'd1});
      if (r.cnt > 1) due_tokens.push_back({r.k1, r.c1, 1'b1});
    end else begin
      for (int i = 0; i < run_n; i++) due_tokens.push_back(run_buf[i]);
    end
    @(negedge clk);
    if (gap > 0) begin
      in_valid   <= 1'b0;
      in_byte    <= 8'($urandom);
      stream_end <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (due_tokens.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls with free-running stretches
  // --------------------------------------------------------------------------
  initial begin : receiver
    int stall_left;
    int free_left;
    stall_left = 0;
    free_left  = 0;
    out_stall  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (free_left > 0) begin
        free_left--;
        out_stall <= 1'b0;
      end else begin
        stall_left = pause_len();
        free_left  = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(0, 12);
        out_stall <= (stall_left > 0);
        if (stall_left > 0) stall_left--;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Token checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_tokens
    token_t want;
    if (!rst && out_valid && !out_stall) begin
      if (due_tokens.size() == 0) begin
        $display("%0t: unexpected token kind=%0d code=%h last=%b",
                 $time, token_kind, char_code, run_last);
        mismatches++;
      end else begin
        want = due_tokens.pop_front();
        if (token_kind !== want.kind) begin
          $display("%0t: token_kind expected %0d got %0d", $time, want.kind, token_kind);
          mismatches++;
        end
        if (char_code !== want.code) begin
          $display("%0t: char_code expected %h got %h", $time, want.code, char_code);
          mismatches++;
        end
        if (run_last !== want.last) begin
          $display("%0t: run_last expected %b got %b", $time, want.last, run_last);
          mismatches++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when nothing moves for too long
  // --------------------------------------------------------------------------
  initial begin : watchdog
    int idle;
    idle = 0;
    @(negedge clk);
    while (rst !== 1'b0) @(negedge clk);
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle = 0;
      else idle++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int sent;
    logic steady;
    logic mid_drained;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h00;
    stream_end = 1'b0;
    tokenizer_clear();

    // comment line, then separator at line start and a second separator
    dir_plan.push_back(plan_row(CH_HASH, 1'b0, 1'b1));
    dir_plan.push_back(plan_row(CH_LF, 1'b0, 1'b1));
    dir_plan.push_back(plan_row(CH_EQ, 1'b0, 1'b1));
    dir_plan.push_back(plan_row(CH_COLON, 1'b0, 1'b1, 2'd1, KIND_VAL, 16'h003A));
    // simple escapes, carriage return escape, pass-through escape, raw CR
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("n", 1'b0, 1'b1, 2'd1, KIND_VAL, 16'h000A));
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("t", 1'b0, 1'b1, 2'd1, KIND_VAL, 16'h0009));
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("r", 1'b0, 1'b1, 2'd1, KIND_VAL, 16'h000D));
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("q", 1'b0, 1'b1, 2'd1, KIND_VAL, 16'h0071));
    dir_plan.push_back(plan_row(CH_CR, 1'b0, 1'b1, 2'd1, KIND_VAL, 16'h000D));
    dir_plan.push_back(plan_row(CH_LF, 1'b0, 1'b1, 2'd1, KIND_END, 16'h0000));
    // extreme bytes in a key, key ended by line feed
    dir_plan.push_back(plan_row(8'h00, 1'b0, 1'b1, 2'd1, KIND_KEY, 16'h0000));
    dir_plan.push_back(plan_row(8'hFF, 1'b0, 1'b1, 2'd1, KIND_KEY, 16'h00FF));
    dir_plan.push_back(plan_row(CH_LF, 1'b0, 1'b1, 2'd1, KIND_END, 16'h0000));
    // full unicode escape in a key
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("u", 1'b0, 1'b1));
    dir_plan.push_back(plan_row("F", 1'b0, 1'b1));
    dir_plan.push_back(plan_row("f", 1'b0, 1'b1));
    dir_plan.push_back(plan_row("0", 1'b0, 1'b1));
    dir_plan.push_back(plan_row("9", 1'b0, 1'b1, 2'd1, KIND_KEY, 16'hFF09));
    // short unicode escape in the value, closed by end of text
    dir_plan.push_back(plan_row(CH_SP, 1'b0, 1'b1));
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("u", 1'b0, 1'b1));
    dir_plan.push_back(plan_row("4", 1'b0, 1'b1));
    dir_plan.push_back(plan_row("g", 1'b1, 1'b0));
    // end of text inside an open unicode escape
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("u", 1'b0, 1'b1));
    dir_plan.push_back(plan_row("C", 1'b1, 1'b0));
    // line continuation inside a key
    dir_plan.push_back(plan_row("v", 1'b0, 1'b1, 2'd1, KIND_KEY, 16'h0076));
    dir_plan.push_back(plan_row(CH_BSL, 1'b0, 1'b1));
    dir_plan.push_back(plan_row(CH_LF, 1'b0, 1'b1));
    dir_plan.push_back(plan_row(CH_SP, 1'b0, 1'b1));
    dir_plan.push_back(plan_row("w", 1'b0, 1'b1, 2'd1, KIND_KEY, 16'h0077));
    dir_plan.push_back(plan_row(CH_BANG, 1'b1, 1'b0));
    // end of text inside a comment
    dir_plan.push_back(plan_row(CH_BANG, 1'b1, 1'b1));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_plan[i]) send_byte(dir_plan[i], pause_len());

    // hold the sender until the block has emptied
    wait_drained();

    sent        = 0;
    mid_drained = 1'b0;
    while (sent < RANDOM_BYTES) begin
      line_q.delete();
      compose_line();
      steady = ($urandom_range(0, 3) == 0);
      foreach (line_q[i]) begin
        send_byte(plan_row(line_q[i], $urandom_range(0, 39) == 0, 1'b0),
                  steady ? 0 : pause_len());
        sent++;
      end
      if (!mid_drained && sent >= RANDOM_BYTES / 2) begin
        wait_drained();
        mid_drained = 1'b1;
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
rtl/pkvt_pkg.sv
rtl/pkvt_front.sv
rtl/pkvt_queue.sv
rtl/pkvt_back.sv
rtl/properties_key_value_tokenizer_core.sv
sim/tb_properties_key_value_tokenizer_core.sv
